// File: rtl/krtt_pkg.sv
package krtt_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned SlotsDefault   = 4;
  localparam int unsigned KeyBitsDefault = 64;

  // Fixed field widths.
  localparam int unsigned StreamKeyBits = 64;
  localparam int unsigned TimeBits      = 63;
  localparam int unsigned PeriodBits    = 16;

  localparam logic [PeriodBits-1:0] PeriodReset = 16'd15;

  // Decision for one request, handed from the table to the result register.
  typedef struct packed {
    logic allow;
    logic untracked;
  } verdict_t;

endpackage

// File: rtl/krtt_table.sv
module krtt_table #(
  parameter int unsigned SLOTS    = krtt_pkg::SlotsDefault,
  parameter int unsigned KEY_BITS = krtt_pkg::KeyBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_valid_i,
  input  logic [KEY_BITS-1:0]               req_key_i,
  input  logic [krtt_pkg::TimeBits-1:0]     req_time_i,
  input  logic [krtt_pkg::PeriodBits-1:0]   min_period_i,
  output krtt_pkg::verdict_t                verdict_o
);

  localparam int unsigned TB = krtt_pkg::TimeBits;
  localparam int unsigned PB = krtt_pkg::PeriodBits;

  logic [SLOTS-1:0]    slot_valid_q;
  logic [KEY_BITS-1:0] slot_key_q  [SLOTS];
  logic [TB-1:0]       slot_time_q [SLOTS];

  logic [SLOTS-1:0] hit_vec;
  logic [SLOTS-1:0] empty_vec;
  logic [SLOTS-1:0] hit_first;
  logic [SLOTS-1:0] empty_first;
  logic             any_hit;
  logic             any_empty;
  logic             key_zero;
  logic [TB-1:0]    hit_time;
  logic [TB:0]      diff;
  logic             pass;
  logic [SLOTS-1:0] wr_time;
  logic [SLOTS-1:0] wr_key;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i]   = slot_valid_q[i] && (slot_key_q[i] == req_key_i);
      empty_vec[i] = !slot_valid_q[i];
    end
  end

  // Isolate the lowest set bit: the lowest-numbered slot wins.
  assign hit_first   = hit_vec & (~hit_vec + SLOTS'(1));
  assign empty_first = empty_vec & (~empty_vec + SLOTS'(1));
  assign any_hit     = |hit_vec;
  assign any_empty   = |empty_vec;
  assign key_zero    = (req_key_i == '0);

  always_comb begin
    hit_time = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_time = hit_time | (slot_time_q[i] & {TB{hit_first[i]}});
    end
  end

  // Top bit of the extended difference is set when time went backwards.
  assign diff = {1'b0, req_time_i} - {1'b0, hit_time};
  assign pass = !diff[TB] && (diff[TB-1:0] >= {{(TB-PB){1'b0}}, min_period_i});

  always_comb begin
    verdict_o.allow     = 1'b1;
    verdict_o.untracked = 1'b0;
    if (key_zero) begin
      verdict_o.untracked = 1'b1;
    end else if (any_hit) begin
      verdict_o.allow = pass;
    end else if (!any_empty) begin
      verdict_o.untracked = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      wr_key[i]  = req_valid_i && !key_zero && !any_hit && empty_first[i];
      wr_time[i] = wr_key[i] || (req_valid_i && !key_zero && hit_first[i] && pass);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else begin
      slot_valid_q <= slot_valid_q | wr_key;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (wr_key[i]) begin
        slot_key_q[i] <= req_key_i;
      end
      if (wr_time[i]) begin
        slot_time_q[i] <= req_time_i;
      end
    end
  end

endmodule

// File: rtl/keyed_rate_throttle_table_top.sv
// Per-stream rate limiter: each request (stream key, millisecond timestamp) is
// taken on start while busy is low, and busy never rises, so a request can be
// issued every cycle. Each request gives exactly one result, shown on allow_o
// and untracked_o with done_o high for one cycle from the rising edge after the
// request register took it; the receiver cannot stall it. The request passes
// through the request register and then the result register, with the slot
// match, the time subtract and the period compare between them. The table
// state is written at the same edge as the result register, so back-to-back
// requests of one key see each other. Key zero is always allowed untracked; a
// full table lets unknown keys through untracked. The minimum period register
// may be written at any time the block holds no request in flight.
module keyed_rate_throttle_table_top #(
  parameter int unsigned SLOTS    = krtt_pkg::SlotsDefault,
  parameter int unsigned KEY_BITS = krtt_pkg::KeyBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [krtt_pkg::StreamKeyBits-1:0]   stream_key_i,
  input  logic [krtt_pkg::TimeBits-1:0]        time_ms_i,
  output logic                                 done_o,
  output logic                                 allow_o,
  output logic                                 untracked_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [krtt_pkg::PeriodBits-1:0]      cfg_data_i
);

  logic                              req_valid_q;
  logic [KEY_BITS-1:0]               req_key_q;
  logic [krtt_pkg::TimeBits-1:0]     req_time_q;
  logic [krtt_pkg::PeriodBits-1:0]   period_q;
  logic                              done_q;
  krtt_pkg::verdict_t                verdict;
  krtt_pkg::verdict_t                verdict_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      done_q      <= 1'b0;
      period_q    <= krtt_pkg::PeriodReset;
    end else begin
      req_valid_q <= start && !busy;
      done_q      <= req_valid_q;
      if (cfg_valid_i && cfg_ready_o) begin
        period_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_key_q  <= stream_key_i[KEY_BITS-1:0];
      req_time_q <= time_ms_i;
    end
    if (req_valid_q) begin
      verdict_q <= verdict;
    end
  end

  krtt_table #(
    .SLOTS    (SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_valid_q),
    .req_key_i    (req_key_q),
    .req_time_i   (req_time_q),
    .min_period_i (period_q),
    .verdict_o    (verdict)
  );

  assign done_o      = done_q;
  assign allow_o     = verdict_q.allow;
  assign untracked_o = verdict_q.untracked;

  // Every accepted transaction produces its result on done_o.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("accepted request produced no result");

  // No result without an earlier accepted transaction.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without a request");

  // Untracked requests are always allowed.
  a_untracked_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && untracked_o) |-> allow_o)
    else $error("untracked request was throttled");

endmodule

// File: tb/keyed_rate_throttle_table_checker.sv
module keyed_rate_throttle_table_checker #(
  parameter int unsigned SLOTS    = krtt_pkg::SlotsDefault,
  parameter int unsigned KEY_BITS = krtt_pkg::KeyBitsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 busy_i,
  input  logic [krtt_pkg::StreamKeyBits-1:0]   stream_key_i,
  input  logic [krtt_pkg::TimeBits-1:0]        time_ms_i,
  input  logic                                 done_i,
  input  logic                                 allow_i,
  input  logic                                 untracked_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [krtt_pkg::PeriodBits-1:0]      cfg_data_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   checked_o,
  output int                                   throttled_o,
  output int                                   untracked_o
);

  localparam logic [63:0] KeyMask     = {64{1'b1}} >> (64 - KEY_BITS);
  localparam int          MaxReported = 40;

  logic [63:0]                     held_key  [SLOTS];
  logic [63:0]                     held_time [SLOTS];
  logic [krtt_pkg::PeriodBits-1:0] min_period;
  krtt_pkg::verdict_t              verdicts_due [$];
  krtt_pkg::verdict_t              due;

  task automatic report_mismatch(input string what);
    fail_count_o++;
    if (fail_count_o <= MaxReported) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // Decides one request against the table and applies its side effects.
  function automatic krtt_pkg::verdict_t throttle_verdict(
    input logic [krtt_pkg::StreamKeyBits-1:0] key_in,
    input logic [krtt_pkg::TimeBits-1:0]      time_in
  );
    logic [63:0]        key;
    logic [63:0]        now;
    logic [63:0]        diff;
    int                 hit;
    int                 empty;
    krtt_pkg::verdict_t v;
    key   = key_in & KeyMask;
    now   = {1'b0, time_in};
    hit   = -1;
    empty = -1;
    v.allow     = 1'b1;
    v.untracked = 1'b1;
    if (key == '0) begin
      return v;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (held_key[i] == '0) begin
        if (empty < 0) empty = i;
      end else if (held_key[i] == key && hit < 0) begin
        hit = i;
      end
    end
    if (hit >= 0) begin
      // The difference is taken modulo 2^64 and its top bit read as a sign.
      diff        = now - held_time[hit];
      v.untracked = 1'b0;
      if (diff[63] || diff < {48'd0, min_period}) begin
        v.allow = 1'b0;
      end else begin
        held_time[hit] = now;
      end
    end else if (empty >= 0) begin
      held_key[empty]  = key;
      held_time[empty] = now;
      v.untracked      = 1'b0;
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_period = krtt_pkg::PeriodReset;
      for (int i = 0; i < SLOTS; i++) begin
        held_key[i]  = '0;
        held_time[i] = '0;
      end
      verdicts_due.delete();
      fail_count_o = 0;
      checked_o    = 0;
      throttled_o  = 0;
      untracked_o  = 0;
    end else begin
      // Results are matched before this edge's request is queued, so a
      // stray result can never pair with an expectation made in the same cycle.
      if (done_i) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("result strobe with no request outstanding");
        end else begin
          due = verdicts_due.pop_front();
          checked_o++;
          if (!due.allow) throttled_o++;
          if (due.untracked) untracked_o++;
          if (allow_i !== due.allow) begin
            report_mismatch($sformatf("allow got %b expected %b", allow_i, due.allow));
          end
          if (untracked_i !== due.untracked) begin
            report_mismatch($sformatf("untracked got %b expected %b",
                                      untracked_i, due.untracked));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        min_period = cfg_data_i;
      end
      if (start_i && !busy_i) begin
        verdicts_due.push_back(throttle_verdict(stream_key_i, time_ms_i));
      end
    end
    pending_o = verdicts_due.size();
  end

endmodule

// File: tb/keyed_rate_throttle_table_top_test.sv
module keyed_rate_throttle_table_top_test;

  localparam int ClkPeriod     = 10;
  localparam int ResetCycles   = 8;
  localparam int ResultLatency = 2;
  localparam int QuietLimit    = 1000;
  localparam int PhaseItems    = 255;

  localparam logic [62:0] TimeMax  = {63{1'b1}};
  localparam logic [62:0] TimeHalf = 63'h4000_0000_0000_0000;

  localparam logic [63:0] KeyA = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] KeyB = 64'h0000_0000_0000_0001;
  localparam logic [63:0] KeyC = 64'h8000_0000_0000_0000;
  localparam logic [63:0] KeyD = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] KeyE = 64'hDEAD_BEEF_0000_0001;

  logic                                clk_i        = 1'b0;
  logic                                rst_ni       = 1'b0;
  logic                                start        = 1'b0;
  logic                                busy;
  logic [krtt_pkg::StreamKeyBits-1:0]  stream_key_i = '0;
  logic [krtt_pkg::TimeBits-1:0]       time_ms_i    = '0;
  logic                                done_o;
  logic                                allow_o;
  logic                                untracked_o;
  logic                                cfg_valid_i  = 1'b0;
  logic                                cfg_ready_o;
  logic [krtt_pkg::PeriodBits-1:0]     cfg_data_i   = '0;

  int          fail_count;
  int          pending;
  int          checked;
  int          throttled;
  int          untracked_seen;
  int          quiet_cycles = 0;
  int          idle_pct     = 15;
  int          requests     = 0;
  int          settings     = 0;
  logic [62:0] clock_ms;
  logic [63:0] tracked_keys [4] = '{KeyA, KeyB, KeyC, KeyD};

  keyed_rate_throttle_table_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .stream_key_i (stream_key_i),
    .time_ms_i    (time_ms_i),
    .done_o       (done_o),
    .allow_o      (allow_o),
    .untracked_o  (untracked_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  keyed_rate_throttle_table_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .stream_key_i (stream_key_i),
    .time_ms_i    (time_ms_i),
    .done_i       (done_o),
    .allow_i      (allow_o),
    .untracked_i  (untracked_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .throttled_o  (throttled),
    .untracked_o  (untracked_seen)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("watchdog: %0d cycles without a transaction", quiet_cycles);
      $display("keyed_rate_throttle_table_top verification failed");
      $finish;
    end
  end

  task automatic issue_request(input logic [63:0] key, input logic [62:0] stamp);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start        <= 1'b1;
    stream_key_i <= key;
    time_ms_i    <= stamp;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    requests++;
  endtask

  // Stops issuing and waits until every outstanding result has been seen.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (ResultLatency + 1) @(posedge clk_i);
  endtask

  task automatic write_min_period(input logic [15:0] value);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  task automatic random_phase(input logic [15:0] period, input int pct);
    logic [63:0] key;
    logic [62:0] stamp;
    int          span;
    int          pick;
    bit          tracked;
    write_min_period(period);
    idle_pct = pct;
    span     = int'(period) / 2 + 4;
    for (int i = 0; i < PhaseItems; i++) begin
      if (i == PhaseItems / 2) drain_results();
      pick    = $urandom_range(0, 99);
      tracked = 1'b0;
      if (pick < 8) begin
        key = '0;
      end else if (pick < 20) begin
        key = {$urandom, $urandom};
      end else begin
        key     = tracked_keys[$urandom_range(0, 3)];
        tracked = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (!tracked && pick < 50) begin
        // The table is full by now, so arbitrary times cannot disturb it.
        stamp = 63'({$urandom, $urandom});
      end else if (pick < 80) begin
        clock_ms = clock_ms + 63'($urandom_range(0, span));
        stamp    = clock_ms;
      end else if (pick < 92) begin
        stamp = clock_ms - 63'($urandom_range(1, span));
      end else if (pick < 96) begin
        stamp = clock_ms;
      end else begin
        clock_ms = clock_ms + 63'({$urandom_range(0, 255), $urandom});
        stamp    = clock_ms;
      end
      issue_request(key, stamp);
    end
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset period of 15 ms: empty keys, claims, hits, backward time, full table.
    issue_request('0, '0);
    issue_request('0, TimeMax);
    issue_request(KeyA, 63'd100);
    issue_request(KeyA, 63'd114);
    issue_request(KeyA, 63'd115);
    issue_request(KeyA, 63'd90);
    issue_request(KeyB, TimeHalf);
    issue_request(KeyB, '0);
    issue_request(KeyC, '0);
    issue_request(KeyC, '0);
    issue_request(KeyD, 63'd500);
    issue_request(KeyE, TimeMax);
    issue_request(KeyE, 63'd7);
    idle_pct = 0;
    issue_request(KeyA, 63'd130);
    issue_request(KeyA, 63'd144);
    issue_request(KeyA, 63'd145);
    idle_pct = 15;
    issue_request('0, 63'd5);

    write_min_period(16'd0);
    issue_request(KeyC, '0);
    issue_request(KeyC, '0);
    issue_request(KeyA, 63'd144);

    write_min_period(16'hFFFF);
    issue_request(KeyD, 63'd500 + 63'd65534);
    issue_request(KeyD, 63'd500 + 63'd65535);
    issue_request(KeyC, 63'd65535);

    // Start above the highest time held so every tracked key can be allowed again.
    clock_ms = TimeHalf + 63'($urandom);
    random_phase(16'd15, 15);
    random_phase(16'd0, 15);
    random_phase(16'hFFFF, 0);
    random_phase(16'd1, 15);
    random_phase(16'($urandom_range(2, 65534)), 15);
    random_phase(16'd40, 15);

    drain_results();
    $display("Sent %0d requests under %0d period writes; %0d results checked, %0d throttled, %0d untracked.",
             requests, settings, checked, throttled, untracked_seen);
    $display("Exercised empty keys, exact-period hits, backward time, a full table, zero and top periods.");
    if (fail_count == 0) begin
      $display("keyed_rate_throttle_table_top verification clean");
    end else begin
      $display("keyed_rate_throttle_table_top verification failed");
    end
    $finish;
  end

endmodule
